### hw/rtl/rxf_pkg.sv
// Shared types and constants for the receive FIFO with realtime filter.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package rxf_pkg;

	// FIFO geometry: a ring of FIFO_CAPACITY+1 slots, full with one slot left
	localparam int FIFO_CAPACITY = 128;
	localparam int RING_SLOTS    = FIFO_CAPACITY + 1;
	localparam int PTR_W         = $clog2(RING_SLOTS);
	localparam int BYTE_W        = 8;
	localparam int DATA_W        = 7;
	localparam int CFG_IDX_W     = 3;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [DATA_W-1:0] data_t;

	// operation codes of an input word
	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_READ  = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESET_CHAR       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STATUS_CHAR      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_START_CHAR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FEED_HOLD_CHAR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_JOG_CANCEL_CHAR  = 3'd4;

	// register reset values
	localparam logic [BYTE_W-1:0] RESET_CHAR_INIT       = 8'd24;
	localparam logic [BYTE_W-1:0] STATUS_CHAR_INIT      = 8'd63;
	localparam logic [BYTE_W-1:0] CYCLE_START_CHAR_INIT = 8'd126;
	localparam logic [BYTE_W-1:0] FEED_HOLD_CHAR_INIT   = 8'd33;
	localparam logic [BYTE_W-1:0] JOG_CANCEL_CHAR_INIT  = 8'd133;

	// one result word
	typedef struct packed {
		logic              read_valid;
		data_t             read_byte;
		logic              event_valid;
		logic [BYTE_W-1:0] event_code;
		logic              overflow_drop;
		logic [BYTE_W-1:0] free_space;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/rxf_channels.sv
// Valid/ready channel interfaces: input words, result words, register writes.
// Depends on rxf_pkg.
`default_nettype none

interface rxf_in_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   opcode;
	logic [rxf_pkg::BYTE_W-1:0]   rx_byte;
	logic                         jog_active;

	modport source (output valid, output opcode, output rx_byte, output jog_active,
		input ready);
	modport sink (input valid, input opcode, input rx_byte, input jog_active,
		output ready);
endinterface

interface rxf_out_if;
	logic                         valid;
	logic                         ready;
	logic                         read_valid;
	logic [rxf_pkg::DATA_W-1:0]   read_byte;
	logic                         event_valid;
	logic [rxf_pkg::BYTE_W-1:0]   event_code;
	logic                         overflow_drop;
	logic [rxf_pkg::BYTE_W-1:0]   free_space;

	modport source (output valid, output read_valid, output read_byte,
		output event_valid, output event_code, output overflow_drop,
		output free_space, input ready);
	modport sink (input valid, input read_valid, input read_byte,
		input event_valid, input event_code, input overflow_drop,
		input free_space, output ready);
endinterface

interface rxf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rxf_pkg::CFG_IDX_W-1:0]  index;
	logic [rxf_pkg::BYTE_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/rx_fifo_with_realtime_filter_core.sv
// Receive FIFO with realtime-command extraction, top level.
// Depends on rxf_pkg and the interfaces in rxf_channels.sv.
// A result word is registered on acceptance; a read that pops first registers the stored byte
// and its pending result, then loads the result word, set by the registered read port of the
// byte store. Input is 1 word per cycle, but not while a popping read or a held result word waits.
// Reset: pointers cleared (FIFO empty), command registers at defaults, no
// clearing pass; the byte store holds no reset value.
`default_nettype none

module rx_fifo_with_realtime_filter_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rxf_in_if.sink     rx_in,
	rxf_out_if.source  rx_out,
	rxf_cfg_if.sink    cfg
);

	// command registers
	logic [rxf_pkg::BYTE_W-1:0] reset_char_q;
	logic [rxf_pkg::BYTE_W-1:0] status_char_q;
	logic [rxf_pkg::BYTE_W-1:0] cycle_start_char_q;
	logic [rxf_pkg::BYTE_W-1:0] feed_hold_char_q;
	logic [rxf_pkg::BYTE_W-1:0] jog_cancel_char_q;

	// ring pointers and byte store
	rxf_pkg::ptr_t   wptr_q, rptr_q;
	rxf_pkg::ptr_t   wptr_nxt, rptr_nxt, wptr_inc, rptr_inc;
	rxf_pkg::data_t  mem_q [rxf_pkg::RING_SLOTS];
	rxf_pkg::data_t  rd_data_s1;
	logic            mem_we;

	// handshake and result state
	logic              pend_s1;
	rxf_pkg::result_t  pend_res_s1;
	rxf_pkg::result_t  out_q;
	logic              out_valid_q;
	logic              accept;
	logic              rd_hit;
	rxf_pkg::result_t  res;
	logic [rxf_pkg::BYTE_W-1:0] held;
	logic [rxf_pkg::BYTE_W-1:0] b;
	logic              is_cmd;

	assign cfg.ready   = 1'b1;
	assign rx_in.ready = !pend_s1 && (!out_valid_q || rx_out.ready);
	assign accept      = rx_in.valid && rx_in.ready;
	assign b           = rx_in.rx_byte;

	// write command registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_char_q       <= rxf_pkg::RESET_CHAR_INIT;
			status_char_q      <= rxf_pkg::STATUS_CHAR_INIT;
			cycle_start_char_q <= rxf_pkg::CYCLE_START_CHAR_INIT;
			feed_hold_char_q   <= rxf_pkg::FEED_HOLD_CHAR_INIT;
			jog_cancel_char_q  <= rxf_pkg::JOG_CANCEL_CHAR_INIT;
		end else if (cfg.valid) begin
			case (cfg.index)
				rxf_pkg::REG_RESET_CHAR:       reset_char_q       <= cfg.data;
				rxf_pkg::REG_STATUS_CHAR:      status_char_q      <= cfg.data;
				rxf_pkg::REG_CYCLE_START_CHAR: cycle_start_char_q <= cfg.data;
				rxf_pkg::REG_FEED_HOLD_CHAR:   feed_hold_char_q   <= cfg.data;
				rxf_pkg::REG_JOG_CANCEL_CHAR:  jog_cancel_char_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// advance pointers around the ring
	assign wptr_inc = (wptr_q == rxf_pkg::ptr_t'(rxf_pkg::RING_SLOTS - 1)) ?
		'0 : wptr_q + 1'b1;
	assign rptr_inc = (rptr_q == rxf_pkg::ptr_t'(rxf_pkg::RING_SLOTS - 1)) ?
		'0 : rptr_q + 1'b1;

	assign is_cmd = (b == reset_char_q) || (b == status_char_q) ||
		(b == cycle_start_char_q) || (b == feed_hold_char_q);

	// decode one input word
	always_comb begin
		res      = '0;
		wptr_nxt = wptr_q;
		rptr_nxt = rptr_q;
		mem_we   = 1'b0;
		rd_hit   = 1'b0;
		case (rx_in.opcode)
			rxf_pkg::OP_BYTE: begin
				if (is_cmd) begin
					res.event_valid = 1'b1;
					res.event_code  = b;
				end else if (b[rxf_pkg::BYTE_W-1]) begin
					if (b == jog_cancel_char_q) begin
						if (rx_in.jog_active) begin
							res.event_valid = 1'b1;
							res.event_code  = b;
							rptr_nxt        = wptr_q;
						end
					end else begin
						res.event_valid = 1'b1;
						res.event_code  = b;
					end
				end else if (wptr_inc != rptr_q) begin
					mem_we   = accept;
					wptr_nxt = wptr_inc;
				end else begin
					res.overflow_drop = 1'b1;
				end
			end
			rxf_pkg::OP_READ: begin
				if (rptr_q != wptr_q) begin
					rd_hit         = 1'b1;
					res.read_valid = 1'b1;
					rptr_nxt       = rptr_inc;
				end
			end
			rxf_pkg::OP_FLUSH: begin
				rptr_nxt = wptr_q;
			end
			default: ;
		endcase
		// free space after this word
		if (wptr_nxt >= rptr_nxt) begin
			held = wptr_nxt - rptr_nxt;
		end else begin
			held = rxf_pkg::BYTE_W'(rxf_pkg::RING_SLOTS) - (rptr_nxt - wptr_nxt);
		end
		res.free_space = rxf_pkg::BYTE_W'(rxf_pkg::FIFO_CAPACITY) - held;
	end

	// byte store: one write port, registered read at the read pointer
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wptr_q] <= b[rxf_pkg::DATA_W-1:0];
		end
		rd_data_s1 <= mem_q[rptr_q];
	end

	// hold pending read result
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_res_s1 <= res;
		end
	end

	// update pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= '0;
			rptr_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				wptr_q <= wptr_nxt;
				rptr_q <= rptr_nxt;
			end
			pend_s1 <= accept && rd_hit;
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (accept && !rd_hit) begin
				out_valid_q <= 1'b1;
			end else if (rx_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// load result payload
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			out_q           <= pend_res_s1;
			out_q.read_byte <= rd_data_s1;
		end else if (accept && !rd_hit) begin
			out_q <= res;
		end
	end

	assign rx_out.valid         = out_valid_q;
	assign rx_out.read_valid    = out_q.read_valid;
	assign rx_out.read_byte     = out_q.read_byte;
	assign rx_out.event_valid   = out_q.event_valid;
	assign rx_out.event_code    = out_q.event_code;
	assign rx_out.overflow_drop = out_q.overflow_drop;
	assign rx_out.free_space    = out_q.free_space;

endmodule

`default_nettype wire

### dv/rx_fifo_with_realtime_filter_core_tb.sv
// Self-checking testbench for the receive FIFO with realtime-command filter.
// Depends on rxf_pkg, the channel interfaces in rxf_channels.sv and the core;
// a local predictor checks every result word, with random stalls on both sides when not calm.
`default_nettype none

module rx_fifo_with_realtime_filter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS   = 200;

	typedef logic [rxf_pkg::BYTE_W-1:0] byte_t;

	typedef struct packed {
		rxf_pkg::opcode_t  op;
		byte_t             rx_byte;
		logic              jog;
	} host_word_t;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// testbench-side drivers, known from time zero
	logic              in_valid = 1'b0;
	logic [1:0]        in_op    = 2'd0;
	byte_t             in_byte  = '0;
	logic              in_jog   = 1'b0;
	logic              out_rdy  = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [rxf_pkg::CFG_IDX_W-1:0] cfg_idx  = '0;
	byte_t                         cfg_data = '0;

	rxf_in_if  in_ch ();
	rxf_out_if out_ch ();
	rxf_cfg_if cfg_ch ();

	assign in_ch.valid      = in_valid;
	assign in_ch.opcode     = in_op;
	assign in_ch.rx_byte    = in_byte;
	assign in_ch.jog_active = in_jog;
	assign out_ch.ready     = out_rdy;
	assign cfg_ch.valid     = cfg_valid;
	assign cfg_ch.index     = cfg_idx;
	assign cfg_ch.data      = cfg_data;

	rx_fifo_with_realtime_filter_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx_in  (in_ch),
		.rx_out (out_ch),
		.cfg    (cfg_ch)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor copy of the ring, pointers and command registers
	rxf_pkg::data_t    ring_copy [0:rxf_pkg::RING_SLOTS-1];
	int                wr_slot;
	int                rd_slot;
	byte_t             cmd_char [0:4];

	host_word_t        host_words [$];
	rxf_pkg::result_t  pending_results [$];
	host_word_t        drv_word;
	rxf_pkg::result_t  want;
	bit         calm;
	int         errors;
	int         n_words, n_pops, n_events, n_drops, n_settings;

	function automatic int next_slot(int p);
		return (p + 1 >= rxf_pkg::RING_SLOTS) ? 0 : p + 1;
	endfunction

	// filter one input word, update the ring copy, return the result word
	function automatic rxf_pkg::result_t rx_filter_step(rxf_pkg::opcode_t op, byte_t b,
			logic jog);
		rxf_pkg::result_t r;
		int held;
		r = '0;
		case (op)
			rxf_pkg::OP_BYTE: begin
				if (b == cmd_char[rxf_pkg::REG_RESET_CHAR] ||
				    b == cmd_char[rxf_pkg::REG_STATUS_CHAR] ||
				    b == cmd_char[rxf_pkg::REG_CYCLE_START_CHAR] ||
				    b == cmd_char[rxf_pkg::REG_FEED_HOLD_CHAR]) begin
					r.event_valid = 1'b1;
					r.event_code  = b;
				end else if (b > 8'h7F) begin
					// jog cancel only acts while jogging; other extended bytes pass as events
					if (b == cmd_char[rxf_pkg::REG_JOG_CANCEL_CHAR]) begin
						if (jog) begin
							r.event_valid = 1'b1;
							r.event_code  = b;
							rd_slot = wr_slot;
						end
					end else begin
						r.event_valid = 1'b1;
						r.event_code  = b;
					end
				end else if (next_slot(wr_slot) != rd_slot) begin
					ring_copy[wr_slot] = b[rxf_pkg::DATA_W-1:0];
					wr_slot = next_slot(wr_slot);
				end else begin
					r.overflow_drop = 1'b1;
				end
			end
			rxf_pkg::OP_READ: begin
				if (rd_slot != wr_slot) begin
					r.read_valid = 1'b1;
					r.read_byte  = ring_copy[rd_slot];
					rd_slot = next_slot(rd_slot);
				end
			end
			rxf_pkg::OP_FLUSH: rd_slot = wr_slot;
			default: ;
		endcase
		held = (wr_slot >= rd_slot) ? wr_slot - rd_slot
			: rxf_pkg::RING_SLOTS - (rd_slot - wr_slot);
		r.free_space = byte_t'(rxf_pkg::FIFO_CAPACITY - held);
		return r;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 9);
	endfunction

	function automatic void push_word(rxf_pkg::opcode_t op, byte_t b, logic jog);
		host_words.push_back('{op, b, jog});
	endfunction

	// bytes (mostly plain, with command, jog-cancel and extended bytes mixed in), reads, flushes, idles
	function automatic host_word_t random_word(mix_t mix);
		host_word_t w;
		int r;
		int s;
		int byte_lim;
		byte_lim = (mix == MIX_FILL) ? 82 : (mix == MIX_DRAIN) ? 30 : 50;
		r = $urandom_range(99);
		s = $urandom_range(99);
		w.jog = 1'($urandom_range(1));
		w.rx_byte = byte_t'($urandom_range(255));
		if (r < byte_lim) begin
			w.op = rxf_pkg::OP_BYTE;
			if (s < 10)
				w.rx_byte = cmd_char[$urandom_range(3)];
			else if (s < 16)
				w.rx_byte = cmd_char[rxf_pkg::REG_JOG_CANCEL_CHAR];
			else if (s < 32)
				w.rx_byte = 8'h80 | byte_t'($urandom_range(127));
			else
				w.rx_byte = byte_t'($urandom_range(127));
		end else if (r < 95) begin
			w.op = rxf_pkg::OP_READ;
		end else if (r < 97) begin
			w.op = rxf_pkg::OP_FLUSH;
		end else begin
			w.op = rxf_pkg::OP_NONE;
		end
		return w;
	endfunction

	// input driver: predict on acceptance, then offer the next queued word
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ch.ready) begin
				pending_results.push_back(rx_filter_step(rxf_pkg::opcode_t'(in_op), in_byte,
					in_jog));
				n_words++;
			end
			if (!in_valid || in_ch.ready) begin
				if (host_words.size() != 0 && !idle_now()) begin
					drv_word = host_words.pop_front();
					in_valid <= 1'b1;
					in_op    <= drv_word.op;
					in_byte  <= drv_word.rx_byte;
					in_jog   <= drv_word.jog;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare each accepted word with the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			out_rdy <= 1'b0;
		end else begin
			if (out_ch.valid && out_rdy) begin
				if (pending_results.size() == 0) begin
					$error("result word arrived with no prediction pending");
					errors++;
				end else begin
					want = pending_results.pop_front();
					n_pops   += want.read_valid;
					n_events += want.event_valid;
					n_drops  += want.overflow_drop;
					if (out_ch.read_valid !== want.read_valid) begin
						$error("read_valid: expected %0d, got %0d", want.read_valid,
							out_ch.read_valid);
						errors++;
					end
					if (out_ch.read_byte !== want.read_byte) begin
						$error("read_byte: expected 0x%02h, got 0x%02h", want.read_byte,
							out_ch.read_byte);
						errors++;
					end
					if (out_ch.event_valid !== want.event_valid) begin
						$error("event_valid: expected %0d, got %0d", want.event_valid,
							out_ch.event_valid);
						errors++;
					end
					if (out_ch.event_code !== want.event_code) begin
						$error("event_code: expected 0x%02h, got 0x%02h", want.event_code,
							out_ch.event_code);
						errors++;
					end
					if (out_ch.overflow_drop !== want.overflow_drop) begin
						$error("overflow_drop: expected %0d, got %0d", want.overflow_drop,
							out_ch.overflow_drop);
						errors++;
					end
					if (out_ch.free_space !== want.free_space) begin
						$error("free_space: expected %0d, got %0d", want.free_space,
							out_ch.free_space);
						errors++;
					end
				end
			end
			out_rdy <= !idle_now();
		end
	end

	// hold until every queued word is accepted and answered, then let the core settle
	task automatic drain();
		while (host_words.size() != 0 || in_valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write one register; caller is at a rising edge and lowers valid afterwards
	task automatic write_reg(input logic [rxf_pkg::CFG_IDX_W-1:0] idx, input byte_t val);
		cfg_valid <= 1'b1;
		cfg_idx   <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cmd_char[idx] = val;
	endtask

	task automatic apply_setting(input byte_t rst_c, input byte_t sts_c,
			input byte_t cyc_c, input byte_t hold_c, input byte_t jog_c);
		drain();
		@(posedge clk);
		write_reg(rxf_pkg::REG_RESET_CHAR, rst_c);
		write_reg(rxf_pkg::REG_STATUS_CHAR, sts_c);
		write_reg(rxf_pkg::REG_CYCLE_START_CHAR, cyc_c);
		write_reg(rxf_pkg::REG_FEED_HOLD_CHAR, hold_c);
		write_reg(rxf_pkg::REG_JOG_CANCEL_CHAR, jog_c);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	initial begin
		mix_t  mix;
		int    burst;
		byte_t jog_c;

		calm = 1'b1;
		wr_slot = 0;
		rd_slot = 0;
		cmd_char[rxf_pkg::REG_RESET_CHAR]       = rxf_pkg::RESET_CHAR_INIT;
		cmd_char[rxf_pkg::REG_STATUS_CHAR]      = rxf_pkg::STATUS_CHAR_INIT;
		cmd_char[rxf_pkg::REG_CYCLE_START_CHAR] = rxf_pkg::CYCLE_START_CHAR_INIT;
		cmd_char[rxf_pkg::REG_FEED_HOLD_CHAR]   = rxf_pkg::FEED_HOLD_CHAR_INIT;
		cmd_char[rxf_pkg::REG_JOG_CANCEL_CHAR]  = rxf_pkg::JOG_CANCEL_CHAR_INIT;
		n_settings = 1;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: empty read, unused opcode, flush on empty, store extremes
		push_word(rxf_pkg::OP_READ, 8'h00, 1'b0);
		push_word(rxf_pkg::OP_NONE, 8'hFF, 1'b1);
		push_word(rxf_pkg::OP_FLUSH, 8'h00, 1'b0);
		push_word(rxf_pkg::OP_BYTE, 8'h00, 1'b0);
		push_word(rxf_pkg::OP_BYTE, 8'h7F, 1'b1);
		push_word(rxf_pkg::OP_BYTE, 8'h55, 1'b0);
		// the four default commands, then plain extended bytes
		push_word(rxf_pkg::OP_BYTE, rxf_pkg::RESET_CHAR_INIT, 1'b0);
		push_word(rxf_pkg::OP_BYTE, rxf_pkg::STATUS_CHAR_INIT, 1'b1);
		push_word(rxf_pkg::OP_BYTE, rxf_pkg::CYCLE_START_CHAR_INIT, 1'b0);
		push_word(rxf_pkg::OP_BYTE, rxf_pkg::FEED_HOLD_CHAR_INIT, 1'b0);
		push_word(rxf_pkg::OP_BYTE, 8'h80, 1'b0);
		push_word(rxf_pkg::OP_BYTE, 8'hFF, 1'b0);
		// jog cancel without jog leaves the FIFO alone; with jog it flushes
		push_word(rxf_pkg::OP_BYTE, rxf_pkg::JOG_CANCEL_CHAR_INIT, 1'b0);
		push_word(rxf_pkg::OP_READ, 8'h00, 1'b0);
		push_word(rxf_pkg::OP_BYTE, rxf_pkg::JOG_CANCEL_CHAR_INIT, 1'b1);
		push_word(rxf_pkg::OP_READ, 8'h00, 1'b1);
		push_word(rxf_pkg::OP_BYTE, 8'h2A, 1'b0);
		push_word(rxf_pkg::OP_FLUSH, 8'hAA, 1'b1);
		push_word(rxf_pkg::OP_READ, 8'h00, 1'b0);
		// fill past full to force drops, then drain past empty
		for (int i = 0; i < rxf_pkg::FIFO_CAPACITY + 2; i++)
			push_word(rxf_pkg::OP_BYTE, byte_t'($urandom_range(64, 125)),
				1'($urandom_range(1)));
		push_word(rxf_pkg::OP_NONE, 8'h00, 1'b0);
		for (int i = 0; i < rxf_pkg::FIFO_CAPACITY + 2; i++)
			push_word(rxf_pkg::OP_READ, byte_t'($urandom_range(255)),
				1'($urandom_range(1)));
		drain();
		calm = 1'b0;

		// extremes: command match beats jog cancel on the same byte
		apply_setting(8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF);
		push_word(rxf_pkg::OP_BYTE, 8'h01, 1'b0);
		push_word(rxf_pkg::OP_BYTE, 8'h02, 1'b0);
		push_word(rxf_pkg::OP_BYTE, 8'hFF, 1'b1);
		push_word(rxf_pkg::OP_BYTE, 8'h00, 1'b0);
		push_word(rxf_pkg::OP_BYTE, 8'h80, 1'b1);
		push_word(rxf_pkg::OP_BYTE, 8'h7F, 1'b0);
		push_word(rxf_pkg::OP_BYTE, 8'h81, 1'b0);
		for (int i = 0; i < 3; i++)
			push_word(rxf_pkg::OP_READ, 8'h00, 1'b0);

		// lowest jog cancel byte
		apply_setting(8'h01, 8'h02, 8'hFE, 8'h40, 8'h80);
		push_word(rxf_pkg::OP_BYTE, 8'h05, 1'b0);
		push_word(rxf_pkg::OP_BYTE, 8'h80, 1'b0);
		push_word(rxf_pkg::OP_BYTE, 8'h80, 1'b1);
		push_word(rxf_pkg::OP_READ, 8'h00, 1'b0);
		push_word(rxf_pkg::OP_BYTE, 8'hFE, 1'b1);

		// jog cancel register below 0x80 never matches; its byte is stored
		apply_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'h41);
		push_word(rxf_pkg::OP_BYTE, 8'h41, 1'b1);
		push_word(rxf_pkg::OP_BYTE, 8'h00, 1'b1);
		push_word(rxf_pkg::OP_BYTE, 8'hC1, 1'b1);
		push_word(rxf_pkg::OP_READ, 8'h00, 1'b0);

		// random phases, each under a fresh register setting
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			jog_c = ($urandom_range(5) == 0) ? byte_t'($urandom_range(127))
				: byte_t'($urandom_range(128, 255));
			apply_setting(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
				byte_t'($urandom_range(255)), byte_t'($urandom_range(255)), jog_c);
			calm = (ph == 2);
			burst = 0;
			mix = MIX_EVEN;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (burst == 0) begin
					mix = mix_t'($urandom_range(2));
					burst = $urandom_range(20, 120);
				end
				host_words.push_back(random_word(mix));
				burst--;
			end
			drain();
		end

		// restore defaults so the reset values are written once too
		apply_setting(rxf_pkg::RESET_CHAR_INIT, rxf_pkg::STATUS_CHAR_INIT,
			rxf_pkg::CYCLE_START_CHAR_INIT, rxf_pkg::FEED_HOLD_CHAR_INIT,
			rxf_pkg::JOG_CANCEL_CHAR_INIT);
		for (int i = 0; i < 40; i++)
			host_words.push_back(random_word(MIX_EVEN));
		drain();

		if (pending_results.size() != 0) begin
			$error("%0d predicted result words never arrived", pending_results.size());
			errors++;
		end
		$display("Covered %0d words under %0d register settings: %0d pops, %0d events,",
			n_words, n_settings, n_pops, n_events);
		$display("%0d overflow drops, with random stalls on both channels.", n_drops);
		if (errors == 0) begin
			$display("[rx_fifo_with_realtime_filter_core] OK");
		end else begin
			$display("[rx_fifo_with_realtime_filter_core] ERROR");
		end
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("[rx_fifo_with_realtime_filter_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
